>>> sv/pfa_pkg.sv
package pfa_pkg;

    // Geometry of the managed window.
    localparam int ADDR_W     = 56;
    localparam int NUM_PAGES  = 16384;
    localparam int PAGE_SHIFT = 12;
    localparam int COUNT_W    = 16;

    // Derived widths.
    localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CNT_W = $clog2(NUM_PAGES + 1);
    localparam int UW    = ADDR_W + 1;

    localparam logic [UW-1:0] PAGE_MASK = (UW'(1) << PAGE_SHIFT) - UW'(1);
    localparam logic [UW-1:0] WIN_BYTES = UW'(NUM_PAGES) << PAGE_SHIFT;
    localparam logic [CNT_W-1:0] NUM_PAGES_CNT = CNT_W'(NUM_PAGES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PAGES - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Action codes.
    localparam logic [2:0] ACT_ALLOC  = 3'd0;
    localparam logic [2:0] ACT_FREE   = 3'd1;
    localparam logic [2:0] ACT_ADDREF = 3'd2;
    localparam logic [2:0] ACT_QUERY  = 3'd3;
    localparam logic [2:0] ACT_INIT   = 3'd4;

    // Status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_BADADDR = 3'd2;
    localparam logic [2:0] ST_ZERO    = 3'd3;
    localparam logic [2:0] ST_OVF     = 3'd4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAM_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_END   = 2'd2;

    // Operation request to the shared adder and its answer.
    typedef struct packed {
        logic [UW-1:0] a;
        logic [UW-1:0] b;
        logic          sub;
    } alu_req_t;

    typedef struct packed {
        logic [UW-1:0] sum;
        logic          lt;
    } alu_rsp_t;

endpackage

>>> sv/pfa_ram.sv
module pfa_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // One registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/pfa_alu.sv
module pfa_alu (
    input  pfa_pkg::alu_req_t req,
    output pfa_pkg::alu_rsp_t rsp
);
    import pfa_pkg::*;

    logic [UW:0] total;

    // Add, or subtract as a plus not-b plus one; the carry out gives a >= b.
    always_comb
    begin
        total   = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
                + {{UW{1'b0}}, req.sub};
        rsp.sum = total[UW-1:0];
        rsp.lt  = req.sub & ~total[UW];
    end

endmodule

>>> sv/refcounted_page_frame_allocator.sv
// Page frame allocator with 16-bit reference counts per frame. Frames are
// handed out from a LIFO stack of page indices; both the stack and the count
// table sit in memories with one write port and one registered read port,
// and the address arithmetic (rounding, checks against the configuration
// registers, page address forming) runs one operation per cycle through a
// single 57-bit adder/comparator under a small sequencer. After reset the
// block clears all NUM_PAGES (16384) entries of the count memory, one entry
// per cycle, before it raises in_ready; configuration writes are taken
// during that pass. One request is worked on at a time, and a finished
// result waits in the output register while the next request is accepted.
// Alloc pops the stack and forms the page address; free and add_ref check
// the address, then read and update the count; query checks the window and
// reads the count; init rounds the bases and pushes the pages of the free
// range; an undefined action goes straight to its result. A result that
// finds the output register still full waits for out_ready.
module refcounted_page_frame_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration writes.
    input  logic                                cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pfa_pkg::ADDR_W-1:0]          cfg_wdata,
    // Request channel.
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          action,
    input  logic [pfa_pkg::ADDR_W-1:0]          page_addr,
    // Result channel.
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pfa_pkg::ADDR_W-1:0]          alloc_addr,
    output logic [pfa_pkg::COUNT_W-1:0]         ref_count,
    output logic [2:0]                          status
);
    import pfa_pkg::*;

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_A0   = 5'd2;
    localparam logic [4:0] S_A1   = 5'd3;
    localparam logic [4:0] S_F0   = 5'd4;
    localparam logic [4:0] S_F1   = 5'd5;
    localparam logic [4:0] S_F2   = 5'd6;
    localparam logic [4:0] S_F3   = 5'd7;
    localparam logic [4:0] S_Q0   = 5'd8;
    localparam logic [4:0] S_Q1   = 5'd9;
    localparam logic [4:0] S_Q2   = 5'd10;
    localparam logic [4:0] S_I0   = 5'd11;
    localparam logic [4:0] S_I1   = 5'd12;
    localparam logic [4:0] S_I2   = 5'd13;
    localparam logic [4:0] S_I3   = 5'd14;
    localparam logic [4:0] S_I4   = 5'd15;
    localparam logic [4:0] S_I5   = 5'd16;
    localparam logic [4:0] S_DONE = 5'd17;

    // Clamp a page count to the number of frames.
    function automatic logic [CNT_W-1:0] page_clamp(input logic [UW-1:0] v);
        if (v >= UW'(NUM_PAGES))
        begin
            return NUM_PAGES_CNT;
        end
        return v[CNT_W-1:0];
    endfunction

    logic [4:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  dram_base_reg, free_start_reg, free_end_reg;
    logic [2:0]         action_reg, action_next;
    logic [ADDR_W-1:0]  pa_reg, pa_next;
    logic [UW-1:0]      first_reg, first_next;
    logic [UW-1:0]      lo_reg, lo_next;
    logic [UW-1:0]      tmp_reg, tmp_next;
    logic               bad_reg, bad_next;
    logic [CNT_W-1:0]   depth_reg, depth_next;
    logic [CNT_W-1:0]   kcnt_reg, kcnt_next;
    logic [CNT_W-1:0]   khi_reg, khi_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [COUNT_W-1:0] res_count_reg, res_count_next;
    logic [2:0]         res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  alloc_addr_reg, alloc_addr_next;
    logic [COUNT_W-1:0] ref_count_reg, ref_count_next;
    logic [2:0]         status_reg, status_next;

    logic [CNT_W-1:0]   depth_dec;
    logic [IDX_W-1:0]   tmp_idx;
    logic [UW-1:0]      alu_shifted;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic               ref_we, ref_re;
    logic [IDX_W-1:0]   ref_waddr, ref_raddr;
    logic [COUNT_W-1:0] ref_wdata, ref_rdata;
    logic               stk_we, stk_re;
    logic [IDX_W-1:0]   stk_waddr, stk_raddr;
    logic [IDX_W-1:0]   stk_wdata, stk_rdata;

    pfa_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Reference counts, one entry per frame.
    pfa_ram #(
        .DEPTH (NUM_PAGES),
        .WIDTH (COUNT_W)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .re    (ref_re),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    // Free stack of page indices.
    pfa_ram #(
        .DEPTH (NUM_PAGES),
        .WIDTH (IDX_W)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign alloc_addr = alloc_addr_reg;
    assign ref_count  = ref_count_reg;
    assign status     = status_reg;

    assign depth_dec   = depth_reg - CNT_W'(1);
    assign tmp_idx     = tmp_reg[PAGE_SHIFT +: IDX_W];
    assign alu_shifted = alu_rsp.sum >> PAGE_SHIFT;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dram_base_reg  <= ADDR_W'(64'h8000_0000);
            free_start_reg <= ADDR_W'(64'h8000_0000);
            free_end_reg   <= ADDR_W'(64'h8000_0000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DRAM_BASE:  dram_base_reg  <= cfg_wdata;
                CFG_FREE_START: free_start_reg <= cfg_wdata;
                CFG_FREE_END:   free_end_reg   <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Sequencer: one adder operation and at most one access per memory a cycle.
    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        pa_next         = pa_reg;
        first_next      = first_reg;
        lo_next         = lo_reg;
        tmp_next        = tmp_reg;
        bad_next        = bad_reg;
        depth_next      = depth_reg;
        kcnt_next       = kcnt_reg;
        khi_next        = khi_reg;
        clr_next        = clr_reg;
        res_addr_next   = res_addr_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        alloc_addr_next = alloc_addr_reg;
        ref_count_next  = ref_count_reg;
        status_next     = status_reg;

        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;

        ref_we    = 1'b0;
        ref_waddr = tmp_idx;
        ref_wdata = '0;
        ref_re    = 1'b0;
        ref_raddr = tmp_idx;
        stk_we    = 1'b0;
        stk_waddr = depth_reg[IDX_W-1:0];
        stk_wdata = tmp_idx;
        stk_re    = 1'b0;
        stk_raddr = depth_dec[IDX_W-1:0];

        case (state_reg)
            S_CLR:
            begin
                ref_we    = 1'b1;
                ref_waddr = clr_reg;
                ref_wdata = '0;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    action_next     = action;
                    pa_next         = page_addr;
                    bad_next        = 1'b0;
                    res_addr_next   = '0;
                    res_count_next  = '0;
                    res_status_next = ST_OK;
                    case (action)
                        ACT_ALLOC:            state_next = S_A0;
                        ACT_FREE, ACT_ADDREF: state_next = S_F0;
                        ACT_QUERY:            state_next = S_Q0;
                        ACT_INIT:             state_next = S_I0;
                        default:              state_next = S_DONE;
                    endcase
                end
            end

            // Alloc: pop the stack while rounding the window base.
            S_A0:
            begin
                if (depth_reg == '0)
                begin
                    res_status_next = ST_EMPTY;
                    state_next      = S_DONE;
                end
                else
                begin
                    stk_re      = 1'b1;
                    depth_next  = depth_dec;
                    alu_req.a   = {1'b0, dram_base_reg};
                    alu_req.b   = PAGE_MASK;
                    first_next  = alu_rsp.sum & ~PAGE_MASK;
                    state_next  = S_A1;
                end
            end

            S_A1:
            begin
                alu_req.a      = first_reg;
                alu_req.b      = UW'(stk_rdata) << PAGE_SHIFT;
                res_addr_next  = alu_rsp.sum[ADDR_W-1:0];
                res_count_next = COUNT_W'(1);
                ref_we         = 1'b1;
                ref_waddr      = stk_rdata;
                ref_wdata      = COUNT_W'(1);
                state_next     = S_DONE;
            end

            // Free and add_ref: offset into the window, alignment and low bound.
            S_F0:
            begin
                alu_req.a   = {1'b0, pa_reg};
                alu_req.b   = {1'b0, dram_base_reg};
                alu_req.sub = 1'b1;
                tmp_next    = alu_rsp.sum;
                bad_next    = alu_rsp.lt | (pa_reg[PAGE_SHIFT-1:0] != '0);
                state_next  = S_F1;
            end

            S_F1:
            begin
                alu_req.a   = {1'b0, pa_reg};
                alu_req.b   = {1'b0, free_start_reg};
                alu_req.sub = 1'b1;
                bad_next    = bad_reg | alu_rsp.lt | (tmp_reg >= WIN_BYTES);
                state_next  = S_F2;
            end

            S_F2:
            begin
                alu_req.a   = {1'b0, pa_reg};
                alu_req.b   = {1'b0, free_end_reg};
                alu_req.sub = 1'b1;
                if (bad_reg || !alu_rsp.lt)
                begin
                    res_status_next = ST_BADADDR;
                    state_next      = S_DONE;
                end
                else
                begin
                    ref_re     = 1'b1;
                    state_next = S_F3;
                end
            end

            // Update the count read in the previous cycle.
            S_F3:
            begin
                alu_req.a   = UW'(ref_rdata);
                alu_req.b   = UW'(1);
                alu_req.sub = (action_reg == ACT_FREE);
                state_next  = S_DONE;
                if (ref_rdata == '0)
                begin
                    res_status_next = ST_ZERO;
                end
                else if (action_reg == ACT_FREE)
                begin
                    ref_we         = 1'b1;
                    ref_wdata      = alu_rsp.sum[COUNT_W-1:0];
                    res_count_next = alu_rsp.sum[COUNT_W-1:0];
                    // Last reference gone: the frame goes back on the stack if it has room.
                    if (alu_rsp.sum[COUNT_W-1:0] == '0 && depth_reg < NUM_PAGES_CNT)
                    begin
                        stk_we     = 1'b1;
                        depth_next = depth_reg + CNT_W'(1);
                    end
                end
                else if (ref_rdata == COUNT_MAX)
                begin
                    res_count_next  = COUNT_MAX;
                    res_status_next = ST_OVF;
                end
                else
                begin
                    ref_we         = 1'b1;
                    ref_wdata      = alu_rsp.sum[COUNT_W-1:0];
                    res_count_next = alu_rsp.sum[COUNT_W-1:0];
                end
            end

            // Query: window check only, then read the count.
            S_Q0:
            begin
                alu_req.a   = {1'b0, pa_reg};
                alu_req.b   = {1'b0, dram_base_reg};
                alu_req.sub = 1'b1;
                tmp_next    = alu_rsp.sum;
                bad_next    = alu_rsp.lt;
                state_next  = S_Q1;
            end

            S_Q1:
            begin
                if (bad_reg || tmp_reg >= WIN_BYTES)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ref_re     = 1'b1;
                    state_next = S_Q2;
                end
            end

            S_Q2:
            begin
                res_count_next = ref_rdata;
                state_next     = S_DONE;
            end

            // Init: round both bases.
            S_I0:
            begin
                depth_next = '0;
                alu_req.a  = {1'b0, dram_base_reg};
                alu_req.b  = PAGE_MASK;
                first_next = alu_rsp.sum & ~PAGE_MASK;
                state_next = S_I1;
            end

            S_I1:
            begin
                alu_req.a  = {1'b0, free_start_reg};
                alu_req.b  = PAGE_MASK;
                lo_next    = alu_rsp.sum & ~PAGE_MASK;
                state_next = S_I2;
            end

            // First page index at or above the rounded free start.
            S_I2:
            begin
                alu_req.a   = lo_reg;
                alu_req.b   = first_reg;
                alu_req.sub = 1'b1;
                kcnt_next   = alu_rsp.lt ? '0 : page_clamp(alu_shifted);
                state_next  = S_I3;
            end

            // Pages k with (k + 1) pages below free end - first are pushed.
            S_I3:
            begin
                alu_req.a   = {1'b0, free_end_reg};
                alu_req.b   = first_reg;
                alu_req.sub = 1'b1;
                if (alu_rsp.lt || alu_rsp.sum == '0)
                begin
                    khi_next   = '0;
                    state_next = S_I5;
                end
                else
                begin
                    tmp_next   = alu_rsp.sum;
                    state_next = S_I4;
                end
            end

            S_I4:
            begin
                alu_req.a   = tmp_reg;
                alu_req.b   = UW'(1);
                alu_req.sub = 1'b1;
                khi_next    = page_clamp(alu_shifted);
                state_next  = S_I5;
            end

            // One page pushed and its count cleared each cycle.
            S_I5:
            begin
                if (kcnt_reg < khi_reg)
                begin
                    stk_we     = 1'b1;
                    stk_wdata  = kcnt_reg[IDX_W-1:0];
                    ref_we     = 1'b1;
                    ref_waddr  = kcnt_reg[IDX_W-1:0];
                    ref_wdata  = '0;
                    depth_next = depth_reg + CNT_W'(1);
                    kcnt_next  = kcnt_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    alloc_addr_next = res_addr_reg;
                    ref_count_next  = res_count_reg;
                    status_next     = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        pa_reg         <= pa_next;
        first_reg      <= first_next;
        lo_reg         <= lo_next;
        tmp_reg        <= tmp_next;
        bad_reg        <= bad_next;
        kcnt_reg       <= kcnt_next;
        khi_reg        <= khi_next;
        res_addr_reg   <= res_addr_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        alloc_addr_reg <= alloc_addr_next;
        ref_count_reg  <= ref_count_next;
        status_reg     <= status_next;
    end

    // The stack never holds more entries than there are frames.
    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= NUM_PAGES_CNT)
        else $error("free stack depth beyond frame count");

    // An accepted request keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready again right after a request");

    // A nonzero allocated address always comes with a count of one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alloc_addr != '0 |-> ref_count == COUNT_W'(1) && status == ST_OK)
        else $error("allocation result with wrong count or status");

    // An empty stack reports neither an address nor a count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> alloc_addr == '0 && ref_count == '0)
        else $error("empty-stack result carries data");

endmodule

>>> sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    // Address arithmetic runs at 64 bits so that rounding past the top of the
    // 56-bit space keeps its carry.
    typedef logic [63:0] wide_t;

    localparam wide_t PAGE_SZ   = wide_t'(1) << PAGE_SHIFT;
    localparam wide_t WIN_SPAN  = wide_t'(NUM_PAGES) << PAGE_SHIFT;
    localparam wide_t ADDR_ALL  = (wide_t'(1) << ADDR_W) - 1;
    localparam int    IDLE_PCT  = 38;
    localparam int    HOLD_LEN  = 300;
    localparam int    HOLD_AT   = 100;
    localparam int    MAX_REPORTS = 40;
    localparam int    STALL_LIMIT = 200000;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
        logic [2:0]         status;
    } frame_result_t;

    typedef struct {
        logic [2:0]        act;
        logic [ADDR_W-1:0] pa;
        bit                drain;
    } frame_req_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [2:0]           action = '0;
    logic [ADDR_W-1:0]    page_addr = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [ADDR_W-1:0]    alloc_addr;
    logic [COUNT_W-1:0]   ref_count;
    logic [2:0]           status;

    refcounted_page_frame_allocator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .page_addr  (page_addr),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .alloc_addr (alloc_addr),
        .ref_count  (ref_count),
        .status     (status)
    );

    always #5 clk = ~clk;

    // Shadow of the allocator: free stack, its depth, counts and registers.
    logic [IDX_W-1:0]   frame_stack [NUM_PAGES];
    logic [CNT_W-1:0]   stack_top;
    logic [COUNT_W-1:0] frame_refs [NUM_PAGES];
    wide_t              cfg_base;
    wide_t              cfg_fstart;
    wide_t              cfg_fend;

    frame_req_t    queued_reqs[$];
    frame_result_t expected_results[$];

    int unsigned n_sent = 0;
    int unsigned n_done = 0;
    int unsigned fail_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned hot_lo = 0;
    int unsigned hot_span = 4;
    int unsigned hold_left = 0;
    bit          calm = 1'b0;
    bit          req_taken = 1'b0;
    bit          held_once = 1'b0;

    function automatic wide_t page_up(wide_t a);
        return (a + PAGE_SZ - 1) & ~(PAGE_SZ - 1);
    endfunction

    // Index of the page holding pa, when pa lies inside the DRAM window.
    function automatic bit in_window(wide_t pa, output int unsigned k);
        k = 0;
        if (pa < cfg_base || pa - cfg_base >= WIN_SPAN)
            return 1'b0;
        k = int'((pa - cfg_base) >> PAGE_SHIFT);
        return 1'b1;
    endfunction

    function automatic void push_frame(int unsigned k);
        if (stack_top < NUM_PAGES_CNT)
        begin
            frame_stack[stack_top] = IDX_W'(k);
            stack_top++;
        end
    endfunction

    // Applies one request to the shadow state and returns its result.
    function automatic frame_result_t predict_frame_op(logic [2:0] act,
                                                       logic [ADDR_W-1:0] addr_in);
        frame_result_t res;
        wide_t         pa;
        wide_t         first;
        wide_t         lo;
        wide_t         p;
        int unsigned   k;
        bit            ok;
        pa = wide_t'(addr_in);
        first = page_up(cfg_base);
        res = '0;
        k = 0;
        case (act)
            ACT_ALLOC:
            begin
                if (stack_top == '0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    stack_top--;
                    k = frame_stack[stack_top];
                    frame_refs[k] = COUNT_W'(1);
                    res.count = COUNT_W'(1);
                    res.addr = ADDR_W'(first + (wide_t'(k) << PAGE_SHIFT));
                end
            end
            ACT_FREE, ACT_ADDREF:
            begin
                ok = (pa & (PAGE_SZ - 1)) == 0 && pa >= cfg_fstart && pa < cfg_fend;
                if (ok)
                    ok = in_window(pa, k);
                if (!ok)
                begin
                    res.status = ST_BADADDR;
                end
                else if (frame_refs[k] == '0)
                begin
                    res.status = ST_ZERO;
                end
                else if (act == ACT_FREE)
                begin
                    frame_refs[k]--;
                    res.count = frame_refs[k];
                    if (frame_refs[k] == '0)
                        push_frame(k);
                end
                else if (frame_refs[k] == COUNT_MAX)
                begin
                    res.count = COUNT_MAX;
                    res.status = ST_OVF;
                end
                else
                begin
                    frame_refs[k]++;
                    res.count = frame_refs[k];
                end
            end
            ACT_QUERY:
            begin
                if (in_window(pa, k))
                    res.count = frame_refs[k];
            end
            ACT_INIT:
            begin
                // Rebuild the stack in ascending order from pages that end below the free end.
                lo = page_up(cfg_fstart);
                stack_top = '0;
                for (k = 0; k < NUM_PAGES; k++)
                begin
                    p = first + (wide_t'(k) << PAGE_SHIFT);
                    if (p - cfg_base >= WIN_SPAN)
                        break;
                    if (p >= lo && p + PAGE_SZ < cfg_fend)
                    begin
                        frame_refs[k] = '0;
                        push_frame(k);
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string field, input wide_t want, input wide_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    endtask

    // Request driver: presents the oldest queued request, with random gaps.
    always @(negedge clk)
    begin : req_driver
        frame_req_t nxt;
        if (rst_n && (!in_valid || req_taken))
        begin
            req_taken = 1'b0;
            if (queued_reqs.size() != 0
                && !(queued_reqs[0].drain && expected_results.size() != 0)
                && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                nxt = queued_reqs.pop_front();
                in_valid <= 1'b1;
                action <= nxt.act;
                page_addr <= nxt.pa;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off to fill the block.
    always @(negedge clk)
    begin : result_sink
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!held_once && n_done >= HOLD_AT)
            begin
                held_once = 1'b1;
                hold_left = HOLD_LEN - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Monitor: predicts on each accepted request, checks each accepted result.
    always @(posedge clk)
    begin : monitor
        frame_result_t want;
        if (rst_n)
        begin
            idle_cycles++;
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_frame_op(action, page_addr));
                req_taken = 1'b1;
                idle_cycles = 0;
            end
            if (out_valid && out_ready)
            begin
                idle_cycles = 0;
                n_done++;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("result with no request outstanding, alloc_addr 0x%0h",
                               alloc_addr);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (alloc_addr !== want.addr)
                        report_mismatch("alloc_addr", want.addr, alloc_addr);
                    if (ref_count !== want.count)
                        report_mismatch("ref_count", want.count, ref_count);
                    if (status !== want.status)
                        report_mismatch("status", want.status, status);
                end
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_req(input logic [2:0] act, input wide_t pa, input bit drain);
        frame_req_t r;
        r.act = act;
        r.pa = ADDR_W'(pa);
        r.drain = drain;
        queued_reqs.push_back(r);
        n_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input wide_t val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= ADDR_W'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DRAM_BASE:  cfg_base = val & ADDR_ALL;
            CFG_FREE_START: cfg_fstart = val & ADDR_ALL;
            CFG_FREE_END:   cfg_fend = val & ADDR_ALL;
            default:        ;
        endcase
    endtask

    task automatic set_window(input wide_t base, input wide_t lo, input wide_t hi);
        write_reg(CFG_DRAM_BASE, base);
        write_reg(CFG_FREE_START, lo);
        write_reg(CFG_FREE_END, hi);
    endtask

    // Point random addresses at the pages around the free range.
    task automatic aim_at_free_range();
        wide_t first;
        first = page_up(cfg_base);
        hot_lo = (cfg_fstart > first) ? int'((cfg_fstart - first) >> PAGE_SHIFT) : 0;
        if (hot_lo > 0)
            hot_lo--;
        hot_span = (cfg_fend > cfg_fstart) ?
                   int'((cfg_fend - cfg_fstart) >> PAGE_SHIFT) + 2 : 4;
    endtask

    // Mostly live page addresses, some misaligned, random or at the edges.
    function automatic wide_t pick_addr();
        int unsigned r;
        wide_t       page;
        r = $urandom_range(99);
        page = page_up(cfg_base) + (wide_t'(hot_lo + $urandom_range(hot_span)) << PAGE_SHIFT);
        if (r < 70)
            return page;
        if (r < 80)
            return page + $urandom_range(PAGE_SZ - 1, 1);
        if (r < 90)
            return wide_t'({$urandom, $urandom});
        case ($urandom_range(5))
            0:       return 0;
            1:       return ADDR_ALL;
            2:       return cfg_fstart;
            3:       return cfg_fend;
            4:       return cfg_fend - PAGE_SZ;
            default: return cfg_base;
        endcase
    endfunction

    task automatic queue_random(input int n, input bit with_init);
        int unsigned r;
        logic [2:0]  act;
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 30)
                act = ACT_ALLOC;
            else if (r < 55)
                act = ACT_FREE;
            else if (r < 70)
                act = ACT_ADDREF;
            else if (r < 88)
                act = ACT_QUERY;
            else if (r < 93 && with_init)
                act = ACT_INIT;
            else
                act = 3'($urandom_range(7, ACT_INIT + 1));
            send_req(act, pick_addr(), 1'b0);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (n_done != n_sent);
    endtask

    initial
    begin : stimulus
        wide_t       b;
        wide_t       lo;
        int unsigned a;

        // Shadow state as it stands after reset.
        stack_top = '0;
        foreach (frame_refs[i])
            frame_refs[i] = '0;
        foreach (frame_stack[i])
            frame_stack[i] = '0;
        cfg_base = 64'h8000_0000;
        cfg_fstart = 64'h8000_0000;
        cfg_fend = 64'h8000_0000;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests; the registers go in during the clearing pass.
        b = 64'h8000_0000;
        set_window(b, b + 3 * PAGE_SZ + 5, b + 12 * PAGE_SZ);
        @(posedge clk);
        send_req(ACT_ALLOC, 0, 1'b0);
        send_req(ACT_QUERY, b, 1'b0);
        send_req(ACT_INIT, 0, 1'b0);
        send_req(ACT_ALLOC, 0, 1'b0);
        send_req(ACT_ADDREF, b + 10 * PAGE_SZ, 1'b1);
        send_req(ACT_QUERY, b + 10 * PAGE_SZ, 1'b0);
        send_req(ACT_FREE, b + 10 * PAGE_SZ, 1'b0);
        send_req(ACT_FREE, b + 10 * PAGE_SZ, 1'b0);
        send_req(ACT_FREE, b + 10 * PAGE_SZ, 1'b0);
        send_req(ACT_ADDREF, b + 10 * PAGE_SZ, 1'b0);
        send_req(ACT_FREE, b + 10 * PAGE_SZ + 1, 1'b0);
        send_req(ACT_FREE, b + 3 * PAGE_SZ, 1'b0);
        send_req(ACT_ADDREF, b + 12 * PAGE_SZ, 1'b0);
        send_req(ACT_FREE, 0, 1'b0);
        send_req(ACT_ADDREF, ADDR_ALL, 1'b0);
        send_req(ACT_QUERY, b + 4 * PAGE_SZ + 123, 1'b0);
        send_req(ACT_QUERY, b - 1, 1'b0);
        send_req(ACT_QUERY, b + WIN_SPAN, 1'b0);
        repeat (4)
            send_req(ACT_ALLOC, ADDR_ALL, 1'b0);
        for (a = ACT_INIT + 1; a < 8; a++)
            send_req(3'(a), ADDR_ALL, 1'b0);
        send_req(ACT_INIT, 0, 1'b0);
        wait_drained();

        // Window at address zero.
        set_window(0, 0, 24 * PAGE_SZ + 7);
        aim_at_free_range();
        @(posedge clk);
        send_req(ACT_INIT, 0, 1'b0);
        queue_random(100, 1'b1);
        wait_drained();

        // Misaligned window base and free range at random.
        b = wide_t'({$urandom, $urandom}) & ((wide_t'(1) << 55) - 1);
        lo = b + $urandom_range(6) * PAGE_SZ + $urandom_range(PAGE_SZ - 1);
        set_window(b, lo, lo + $urandom_range(40, 8) * PAGE_SZ + $urandom_range(PAGE_SZ - 1));
        aim_at_free_range();
        @(posedge clk);
        send_req(ACT_INIT, 0, 1'b0);
        queue_random(100, 1'b1);
        wait_drained();

        // Every page of the window on the stack; work near the top of it.
        b = (wide_t'({$urandom, $urandom}) & ((wide_t'(1) << 55) - 1)) & ~(PAGE_SZ - 1);
        set_window(b, b, ADDR_ALL);
        hot_lo = NUM_PAGES - 40;
        hot_span = 39;
        @(posedge clk);
        send_req(ACT_INIT, 0, 1'b0);
        queue_random(100, 1'b0);
        wait_drained();

        // Registers at their extremes: nothing can be pushed.
        set_window(ADDR_ALL, ADDR_ALL, 0);
        @(posedge clk);
        send_req(ACT_INIT, 0, 1'b0);
        send_req(ACT_ALLOC, 0, 1'b0);
        send_req(ACT_FREE, ADDR_ALL, 1'b0);
        send_req(ACT_ADDREF, 0, 1'b0);
        send_req(ACT_QUERY, ADDR_ALL, 1'b0);
        send_req(ACT_QUERY, 0, 1'b0);
        wait_drained();
        set_window(ADDR_ALL, 0, ADDR_ALL);
        @(posedge clk);
        send_req(ACT_INIT, 0, 1'b0);
        send_req(ACT_ALLOC, 0, 1'b0);
        send_req(ACT_QUERY, ADDR_ALL, 1'b0);
        wait_drained();

        // Drive one count up and part of the way back down, back to back with no idling.
        b = 64'h8000_0000;
        set_window(b, b, b + 3 * PAGE_SZ);
        @(posedge clk);
        calm = 1'b1;
        send_req(ACT_INIT, 0, 1'b0);
        send_req(ACT_ALLOC, 0, 1'b0);
        repeat (50)
            send_req(ACT_ADDREF, b + PAGE_SZ, 1'b0);
        send_req(ACT_QUERY, b + PAGE_SZ, 1'b0);
        repeat (10)
            send_req(ACT_FREE, b + PAGE_SZ, 1'b0);
        wait_drained();
        calm = 1'b0;

        // Let any stray result show up before the verdict.
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
sv/pfa_pkg.sv
sv/pfa_ram.sv
sv/pfa_alu.sv
sv/refcounted_page_frame_allocator.sv
sim/tb.sv
